// ===== rtl/woi_pkg.sv =====
package woi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TRIG_WIDTH   = 18;

  localparam int ATAN_LEN  = 30;
  localparam int ATAN_IDXW = 5;
  localparam int CORDIC_N  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int STEP_W    = $clog2(CORDIC_N + 1);
  localparam int XY_W      = TRIG_WIDTH + 1;
  localparam int TRIG_FRAC = TRIG_WIDTH - 2;

  localparam longint unsigned GAIN_Q32 = 64'd2608131496;
  localparam longint unsigned X_INIT_L =
    (GAIN_Q32 + (64'd1 << (33 - TRIG_WIDTH))) >> (34 - TRIG_WIDTH);

  localparam logic [1:0] REG_DIST  = 2'd0;
  localparam logic [1:0] REG_ANGLE = 2'd1;

  typedef struct packed {
    logic signed [31:0] dt;
    logic signed [31:0] dr;
  } delta_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
  } pose_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ang;
  } cordic_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [TRIG_WIDTH-1:0] c;
    logic signed [TRIG_WIDTH-1:0] s;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_at(input logic [ATAN_IDXW-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/wheel_odometry_integrator_top.sv =====
// Flow: each request passes the 16-step CORDIC and four products on a shared multiplier,
// then its result is written to the output queue; requests are worked on one at a time.
// Two requests and two results queue up.
// Reset: synchronous active-low rst_n clears pose, totals, scale registers and queues;
// the first request after reset gives zero deltas.
module wheel_odometry_integrator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_travel_count,
  input  logic [31:0]        in_turn_count,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata
);
  import woi_pkg::*;

  logic        dq_empty, dq_pop, oq_full, oq_push;
  delta_t      dq_data;
  cordic_req_t creq;
  cordic_rsp_t crsp;
  pose_t       oq_wdata, oq_rdata;

  woi_front u_front (
    .clk, .rst_n, .push(in_push), .full(in_full),
    .travel_count(in_travel_count), .turn_count(in_turn_count),
    .dq_empty, .dq_pop, .dq_data
  );

  woi_cordic u_cordic (.clk, .rst_n, .req(creq), .rsp(crsp));

  woi_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .dq_empty, .dq_pop, .dq_data, .creq, .crsp,
    .oq_full, .oq_push, .oq_data(oq_wdata)
  );

  woi_outq u_outq (
    .clk, .rst_n, .push(oq_push), .wdata(oq_wdata), .full(oq_full),
    .pop(out_pop), .empty(out_empty), .rdata(oq_rdata)
  );

  assign out_pos_x   = oq_rdata.pos_x;
  assign out_pos_y   = oq_rdata.pos_y;
  assign out_heading = oq_rdata.heading;
endmodule

// ===== rtl/woi_front.sv =====
module woi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [31:0]     travel_count,
  input  logic [31:0]     turn_count,
  output logic            dq_empty,
  input  logic            dq_pop,
  output woi_pkg::delta_t dq_data
);
  import woi_pkg::*;

  logic [31:0] prev_travel_r, prev_turn_r;
  logic        first_r;
  delta_t      mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        acc, pop_ok;
  delta_t      d;

  assign full     = (cnt_r == 2'd2);
  assign dq_empty = (cnt_r == 2'd0);
  assign dq_data  = mem_r[rp_r];
  assign acc      = push && !full;
  assign pop_ok   = dq_pop && !dq_empty;

  always_comb begin
    d.dt = first_r ? 32'sd0 : $signed(travel_count - prev_travel_r);
    d.dr = first_r ? 32'sd0 : $signed(turn_count - prev_turn_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_travel_r <= '0;
      prev_turn_r   <= '0;
      first_r       <= 1'b1;
      wp_r          <= 1'b0;
      rp_r          <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (acc) begin
        prev_travel_r <= travel_count;
        prev_turn_r   <= turn_count;
        first_r       <= 1'b0;
        mem_r[wp_r]   <= d;
        wp_r          <= ~wp_r;
      end
      if (pop_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, pop_ok};
    end
  end
endmodule

// ===== rtl/woi_cordic.sv =====
module woi_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  woi_pkg::cordic_req_t req,
  output woi_pkg::cordic_rsp_t rsp
);
  import woi_pkg::*;

  localparam logic signed [XY_W-1:0] X_INIT = XY_W'(X_INIT_L);
  localparam logic signed [XY_W+1:0] ONE_P  = (XY_W+2)'(1) <<< TRIG_FRAC;

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [32:0]     z_r;
  logic [1:0]             quad_r;
  logic [STEP_W-1:0]      cnt_r;
  logic                   busy_r, done_r;
  logic signed [TRIG_WIDTH-1:0] c_r, s_r;
  logic [31:0]            t;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [32:0]     at;
  logic signed [XY_W+1:0] cx, cy, cc, cs;

  assign t  = req.ang + 32'h20000000;
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = $signed({1'b0, atan_at(ATAN_IDXW'(cnt_r))});

  function automatic logic signed [TRIG_WIDTH-1:0] clampt(input logic signed [XY_W+1:0] v);
    logic signed [TRIG_WIDTH-1:0] r;
    if (v > ONE_P) r = TRIG_WIDTH'(ONE_P);
    else if (v < -ONE_P) r = TRIG_WIDTH'(-ONE_P);
    else r = v[TRIG_WIDTH-1:0];
    return r;
  endfunction

  always_comb begin
    cx = (XY_W+2)'(x_r);
    cy = (XY_W+2)'(y_r);
    unique case (quad_r)
      2'd0: begin cc = cx;  cs = cy;  end
      2'd1: begin cc = -cy; cs = cx;  end
      2'd2: begin cc = -cx; cs = -cy; end
      default: begin cc = cy; cs = -cx; end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.c    = c_r;
  assign rsp.s    = s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r    <= X_INIT;
        y_r    <= '0;
        z_r    <= $signed({3'b0, t[29:0]}) - 33'sh20000000;
        quad_r <= t[31:30];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == STEP_W'(CORDIC_N)) begin
          c_r    <= clampt(cc);
          s_r    <= clampt(cs);
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/woi_outq.sv =====
module woi_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  woi_pkg::pose_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output woi_pkg::pose_t rdata
);
  import woi_pkg::*;

  pose_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wdata;
        wp_r        <= ~wp_r;
      end
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== rtl/woi_back.sv =====
module woi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [31:0]          cfg_wdata,
  input  logic                 dq_empty,
  output logic                 dq_pop,
  input  woi_pkg::delta_t      dq_data,
  output woi_pkg::cordic_req_t creq,
  input  woi_pkg::cordic_rsp_t crsp,
  input  logic                 oq_full,
  output logic                 oq_push,
  output woi_pkg::pose_t       oq_data
);
  import woi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MD   = 4'd1;
  localparam logic [3:0] S_MR   = 4'd2;
  localparam logic [3:0] S_CR   = 4'd3;
  localparam logic [3:0] S_MX   = 4'd4;
  localparam logic [3:0] S_MY   = 4'd5;
  localparam logic [3:0] S_AY   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] dpc_r, apc_r;
  delta_t      d_r;
  logic signed [31:0] dist_r, acc_x_r, acc_y_r;
  logic        [31:0] heading_r, yaw_r;
  logic signed [TRIG_WIDTH-1:0] c_r, s_r;
  logic signed [63:0] prod_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] psh;

  assign prod = mul_a * mul_b;
  assign psh  = prod_r >>> TRIG_FRAC;

  always_comb begin
    unique case (state_r)
      S_MD:    begin mul_a = 33'(d_r.dt);   mul_b = $signed({1'b0, dpc_r}); end
      S_MR:    begin mul_a = 33'(d_r.dr);   mul_b = $signed({1'b0, apc_r}); end
      S_MX:    begin mul_a = 33'(dist_r);   mul_b = 33'(c_r); end
      default: begin mul_a = 33'(dist_r);   mul_b = 33'(s_r); end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!dq_empty) state_nxt = S_MD;
      S_MD:   state_nxt = S_MR;
      S_MR:   state_nxt = S_CR;
      S_CR:   if (crsp.done) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_AY;
      S_AY:   state_nxt = S_OUT;
      S_OUT:  if (!oq_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign dq_pop       = (state_r == S_IDLE) && !dq_empty;
  assign creq.start   = (state_r == S_MD);
  assign creq.ang     = heading_r;
  assign oq_push      = (state_r == S_OUT) && !oq_full;
  assign oq_data.pos_x   = acc_x_r;
  assign oq_data.pos_y   = acc_y_r;
  assign oq_data.heading = heading_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dpc_r     <= '0;
      apc_r     <= '0;
      acc_x_r   <= '0;
      acc_y_r   <= '0;
      heading_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_idx == REG_DIST)  dpc_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_ANGLE) apc_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: if (!dq_empty) d_r <= dq_data;
        S_MD:   prod_r <= prod[63:0];
        S_MR: begin
          dist_r <= sat32(prod_r >>> 16);
          prod_r <= prod[63:0];
        end
        S_CR: begin
          yaw_r <= prod_r[47:16];
          if (crsp.done) begin
            c_r <= crsp.c;
            s_r <= crsp.s;
          end
        end
        S_MX:   prod_r <= prod[63:0];
        S_MY: begin
          acc_x_r <= sat32(psh + 64'(acc_x_r));
          prod_r  <= prod[63:0];
        end
        S_AY: begin
          acc_y_r   <= sat32(psh + 64'(acc_y_r));
          heading_r <= heading_r + yaw_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import woi_pkg::*;

  localparam logic [1:0] REG_BAD = 2'd2;
  localparam int CYCLE_LIMIT = 1000000;

  class pose_scoreboard;
    logic [31:0] dist_scale, angle_scale;
    logic [31:0] last_travel, last_turn;
    bit          first_pending;
    logic signed [31:0] x_acc, y_acc;
    logic [31:0] head_acc;
    pose_t       pending[$];
    int          errors;
    int          checked;

    function new();
      dist_scale = 0; angle_scale = 0; last_travel = 0; last_turn = 0;
      first_pending = 1; x_acc = 0; y_acc = 0; head_acc = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_DIST) dist_scale = val;
      else if (idx == REG_ANGLE) angle_scale = val;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void sincos(logic [31:0] ang, output longint c, output longint s);
      logic [31:0] t;
      longint z, x, y, nx, ny, one;
      t = ang + 32'h20000000;
      z = longint'({34'd0, t[29:0]}) - 64'sh20000000;
      one = 64'sd1 <<< TRIG_FRAC;
      x = longint'(X_INIT_L);
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i);
          z = z - longint'({32'd0, atan_at(i[ATAN_IDXW-1:0])});
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i);
          z = z + longint'({32'd0, atan_at(i[ATAN_IDXW-1:0])});
        end
        x = nx; y = ny;
      end
      case (t[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      if (c > one) c = one; else if (c < -one) c = -one;
      if (s > one) s = one; else if (s < -one) s = -one;
    endfunction

    function void note_request(logic [31:0] travel, logic [31:0] turn);
      longint dt, dr, step_len, c, s;
      logic [31:0] d;
      logic [63:0] yaw;
      pose_t p;
      dt = 0; dr = 0;
      if (!first_pending) begin
        d = travel - last_travel; dt = longint'($signed(d));
        d = turn - last_turn; dr = longint'($signed(d));
      end
      last_travel = travel; last_turn = turn; first_pending = 0;
      step_len = clamp32((dt * longint'({32'd0, dist_scale})) >>> 16);
      sincos(head_acc, c, s);
      x_acc = clamp32(longint'(x_acc) + ((step_len * c) >>> TRIG_FRAC));
      y_acc = clamp32(longint'(y_acc) + ((step_len * s) >>> TRIG_FRAC));
      yaw = 64'(dr) * {32'd0, angle_scale};
      head_acc = head_acc + yaw[47:16];
      p.pos_x = x_acc; p.pos_y = y_acc; p.heading = head_acc;
      pending.push_back(p);
    endfunction

    function void check_result(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] h);
      pose_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h heading=%h", $time, x, y, h);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.pos_x) begin
        $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, x); errors++;
      end
      if (y !== e.pos_y) begin
        $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, y); errors++;
      end
      if (h !== e.heading) begin
        $display("%0t: heading expected %h actual %h", $time, e.heading, h); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0, in_full;
  logic [31:0] in_travel_count = 0, in_turn_count = 0;
  logic out_empty, out_pop = 0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0] out_heading;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = 0;
  logic [31:0] cfg_wdata = 0;

  pose_scoreboard sb = new();
  int send_idle, recv_idle;
  bit hold_req;
  int hold_cnt;
  int cycles;
  logic [31:0] travel_tot, turn_tot;

  wheel_odometry_integrator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_travel_count(in_travel_count), .in_turn_count(in_turn_count),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (out_pop && !out_empty) sb.check_result(out_pos_x, out_pos_y, out_heading);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 300;
        out_pop <= 0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_request(logic [31:0] travel, logic [31:0] turn);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_travel_count <= travel;
    in_turn_count <= turn;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_request(travel, turn);
    travel_tot = travel;
    turn_tot = turn;
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_burst(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 80)
        send_request(travel_tot + 32'($signed($urandom_range(4000)) - 2000),
                     turn_tot + 32'($signed($urandom_range(4000)) - 2000));
      else if (k < 90)
        send_request(travel_tot + 32'h80000000, turn_tot + $urandom);
      else
        send_request($urandom, $urandom);
    end
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(REG_DIST, $urandom);
      1: write_reg(REG_DIST, $urandom_range(32'h0004_0000));
      2: write_reg(REG_DIST, 32'hFFFFFFFF);
      default: write_reg(REG_DIST, 32'h1000_0000);
    endcase
    case ($urandom_range(2))
      0: write_reg(REG_ANGLE, $urandom);
      1: write_reg(REG_ANGLE, $urandom_range(32'h0100_0000));
      default: write_reg(REG_ANGLE, 32'hFFFFFFFF);
    endcase
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    hold_cnt = 0;
    cycles = 0;
    travel_tot = 0;
    turn_tot = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_request(32'h1234_5678, 32'h9ABC_DEF0);
    send_request(32'h1234_5678 + 100, 32'h9ABC_DEF0 - 50);
    drain();
    write_reg(REG_DIST, 32'hFFFFFFFF);
    write_reg(REG_ANGLE, 32'hFFFFFFFF);
    write_reg(REG_BAD, 32'h0);
    write_reg(REG_BAD + 2'd1, 32'h0);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_request(travel_tot + 32'h7FFF_FFFF, turn_tot + 32'h1000);
    for (int i = 0; i < 6; i++) send_request(travel_tot - 32'h7FFF_FFFF, turn_tot + 32'h4000_0000);
    drain();
    write_reg(REG_DIST, 32'h0001_0000);
    write_reg(REG_ANGLE, 32'h0001_0000);
    send_request(travel_tot + 1000, turn_tot + 32'h4000_0000);
    send_request(travel_tot + 1000, turn_tot + 32'h4000_0000);
    send_request(travel_tot - 1, turn_tot - 1);
    send_request(travel_tot, turn_tot);
    drain();

    send_idle = 14; recv_idle = 61;
    for (int p = 0; p < 4; p++) begin
      random_config();
      random_burst(45);
      drain();
    end
    hold_req = 1;
    random_burst(12);
    drain();

    send_idle = 61; recv_idle = 14;
    for (int p = 0; p < 4; p++) begin
      random_config();
      random_burst(45);
      drain();
    end

    send_idle = 0; recv_idle = 0;
    for (int p = 0; p < 3; p++) begin
      random_config();
      random_burst(50);
      drain();
    end
    write_reg(REG_DIST, 32'h0);
    write_reg(REG_ANGLE, 32'h0);
    random_burst(10);
    drain();

    $display("tb_top: %0d poses compared across scale settings from zero to full range,",
             sb.checked);
    $display("tb_top: with wrap, half-turn, saturation, long output stall and idle mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== wheel_odometry_integrator_top.f =====
rtl/woi_pkg.sv
rtl/woi_front.sv
rtl/woi_cordic.sv
rtl/woi_outq.sv
rtl/woi_back.sv
rtl/wheel_odometry_integrator_top.sv
tb/sv/tb_top.sv
